// ===== hdl/itoa_pkg.sv =====
// shared constants, types and helper functions for the integer to ascii converter
package itoa_pkg;

	// default width of the input word
	localparam int VALUE_BITS_DEF = 32;
	// dividend bits retired per divider cycle
	localparam int STEP_BITS = 8;
	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_TEN = 6'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // latch a new word
		logic step;   // run one divider cycle
		logic last;   // this divider cycle finishes a digit
		logic sign;   // put the minus sign on the output
		logic rd;     // read one stored digit, move pointer down
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic quo_zero;  // quotient of the current divider cycle is zero
		logic neg;       // word is negative in radix ten
		logic ptr_zero;  // read pointer at the least significant digit
	} stat_t;

	// clamp register value into the usable radix range
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// digit below 36 to its ascii character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d > DIGIT_NINE) begin
			res = CH_LOWER_A + CHAR_W'(d - DIGIT_TEN);
		end else begin
			res = CH_ZERO + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

// ===== hdl/itoa_ram.sv =====
// generic single write port ram with registered read
module itoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/itoa_dp.sv =====
// datapath: radix register, digit divider, digit stack and output register
module itoa_dp import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [RADIX_W-1:0]    cfg_wdata,
	input  logic [VALUE_BITS-1:0] value,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic                  valid,
	output logic [CHAR_W-1:0]     ascii_char,
	output logic                  last_char
);

	localparam int CYC = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W = CYC * STEP_BITS;
	localparam int AW = $clog2(VALUE_BITS);

	logic [RADIX_W-1:0]   radix_q;
	logic [RADIX_W-1:0]   r_q;
	logic                 neg_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [AW-1:0]        cnt_q;
	logic [AW-1:0]        ptr_q;
	logic                 rd_s1;
	logic                 lst_s1;
	logic                 valid_q;
	logic [CHAR_W-1:0]    ascii_q;
	logic                 last_q;

	logic [RADIX_W-1:0]   r_in;
	logic                 neg_in;
	logic [VALUE_BITS-1:0] mag;
	logic [DIGIT_W-1:0]   rem_w;
	logic [STEP_BITS-1:0] qbits;
	logic [DIGIT_W:0]     t;
	logic [DIV_W-1:0]     quo_next;
	logic [DIGIT_W-1:0]   rdata;
	logic                 wr_digit;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// magnitude and sign of the incoming word
	assign r_in = eff_radix(radix_q);
	assign neg_in = (r_in == RADIX_TEN) && value[VALUE_BITS-1];
	assign mag = neg_in ? VALUE_BITS'(~value + 1'b1) : value;

	// restoring division, STEP_BITS quotient bits per cycle
	always_comb begin
		rem_w = rem_q;
		qbits = '0;
		t = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {rem_w, quo_q[DIV_W-1-i]};
			if (t >= {1'b0, r_q}) begin
				rem_w = DIGIT_W'(t - {1'b0, r_q});
				qbits[STEP_BITS-1-i] = 1'b1;
			end else begin
				rem_w = DIGIT_W'(t);
			end
		end
	end

	assign quo_next = DIV_W'({quo_q, qbits});
	assign wr_digit = cmd.step && cmd.last;

	// divider and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= RADIX_RESET;
			rem_q <= '0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (cmd.load) begin
			r_q <= r_in;
			rem_q <= '0;
			neg_q <= neg_in;
			cnt_q <= '0;
		end else if (cmd.step) begin
			if (cmd.last) begin
				rem_q <= '0;
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= cnt_q;
			end else begin
				rem_q <= rem_w;
			end
		end else if (cmd.rd) begin
			ptr_q <= ptr_q - 1'b1;
		end
	end

	// dividend / quotient shift register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= DIV_W'(mag);
		end else if (cmd.step) begin
			quo_q <= quo_next;
		end
	end

	// digit stack, least significant digit at address zero
	itoa_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_ram (
		.clk(clk),
		.we(wr_digit),
		.waddr(cnt_q),
		.wdata(rem_w),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// read pipeline and output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			valid_q <= cmd.sign || rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		lst_s1 <= stat.ptr_zero;
		ascii_q <= cmd.sign ? CH_MINUS : digit_char(rdata);
		last_q <= cmd.sign ? 1'b0 : lst_s1;
	end

	assign stat.quo_zero = (quo_next == '0);
	assign stat.neg = neg_q;
	assign stat.ptr_zero = (ptr_q == '0);

	assign valid = valid_q;
	assign ascii_char = ascii_q;
	assign last_char = last_q;

	// remainder stays a valid digit of the latched radix
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n) rem_q < r_q)
		else $error("remainder not below radix");

	// latched radix stays clamped
	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(r_q >= RADIX_MIN) && (r_q <= RADIX_MAX))
		else $error("latched radix out of range");

	// sign and digit words never compete for the output register
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n) !(cmd.sign && rd_s1))
		else $error("sign and digit collide");

endmodule

// ===== hdl/itoa_ctrl.sv =====
// controller: sequences load, digit division, sign and digit readout
module itoa_ctrl import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output cmd_t  cmd,
	input  stat_t stat
);

	localparam int CYC = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int STEP_CW = (CYC > 1) ? $clog2(CYC) : 1;
	localparam logic [STEP_CW-1:0] STEP_LAST = STEP_CW'(CYC - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ
	} state_t;

	state_t             state_q;
	logic [STEP_CW-1:0] step_q;

	// commands decoded from state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cmd.last = (step_q == STEP_LAST);
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_LAST) begin
						step_q <= '0;
						if (stat.quo_zero) begin
							state_q <= stat.neg ? ST_SIGN : ST_READ;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SIGN: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (stat.ptr_zero) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// busy only rises on an accepted word
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	// step counter never passes the last divider cycle
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n) step_q <= STEP_LAST)
		else $error("step counter out of range");

	// a nonzero quotient always starts another digit
	a_next_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && cmd.last && !stat.quo_zero |=>
		(state_q == ST_DIV) && (step_q == '0))
		else $error("digit loop left early");

endmodule

// ===== hdl/integer_to_ascii_radix_top.sv =====
// top level of the integer to ascii text converter
//
// Usage: pulse start with value while busy is low; the word is accepted at that
// edge and busy rises. The text comes out one ascii character per word on
// ascii_char, each marked by valid for exactly one cycle, most significant
// character first; last_char marks the final one. The receiver cannot stall.
// The user must write the radix register through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce it. 0 and 1 act as 2, 37 to 63
// act as 36. Negative words get a '-' only in radix ten, otherwise unsigned.
// Each digit is one pass of the divider over the word, 8 quotient bits per
// cycle; busy stays high through the division, the sign if any and the
// readout. Digits leave the digit stack ram one per cycle; characters come
// out through the registered ram read and the output register, so the last
// character shows in the cycle after busy falls. Worst case at 32 bits is
// radix two, 32 digits. Reset clears control and sets radix to 10.
module integer_to_ascii_radix_top import itoa_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [RADIX_W-1:0]           cfg_wdata,
	input  logic                         start,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         busy,
	output logic                         valid,
	output logic [CHAR_W-1:0]            ascii_char,
	output logic                         last_char
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	itoa_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.stat(stat)
	);

	// divider, digit stack and output
	itoa_dp #(
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.value(value),
		.cmd(cmd),
		.stat(stat),
		.valid(valid),
		.ascii_char(ascii_char),
		.last_char(last_char)
	);

endmodule
